### rtl/core/complex_alu_with_magnitude_top_defines.svh
// Assertion macros for the complex ALU with magnitude.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef COMPLEX_ALU_WITH_MAGNITUDE_TOP_DEFINES_SVH
`define COMPLEX_ALU_WITH_MAGNITUDE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Expression must hold at every clock edge outside reset.
`define CAWM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// Antecedent implies consequent sequence in the same cycle.
`define CAWM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);
`else
`define CAWM_ASSERT(lbl, expr, msg)
`define CAWM_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/cawm_pkg.sv
// Shared types, widths and helpers for the complex ALU with magnitude.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package cawm_pkg;

  // Number format
  localparam int DataWidth = 16;
  localparam int FracBits  = 8;

  // Derived widths
  localparam int ProdW = 2 * DataWidth;      // full product
  localparam int SumW  = 2 * DataWidth + 1;  // sum of two products
  localparam int RadW  = 2 * DataWidth;      // square root radicand
  localparam int RemW  = DataWidth + 3;      // square root remainder

  typedef enum logic [2:0] {
    CmdAdd  = 3'd0,
    CmdSub  = 3'd1,
    CmdMul  = 3'd2,
    CmdConj = 3'd3,
    CmdMag  = 3'd4
  } cmd_e;

  // Saturated value with its flag
  typedef struct packed {
    logic [DataWidth-1:0] val;
    logic                 ovf;
  } sat_t;

  // Result carried alongside the root computation
  typedef struct packed {
    logic [DataWidth-1:0] re;
    logic [DataWidth-1:0] im;
    logic                 ovf;
    logic                 mag;
  } pay_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic                 vld;
    logic [RadW-1:0]      rad;
    logic [RemW-1:0]      rem;
    logic [DataWidth-1:0] root;
    pay_t                 pay;
  } cell_t;

  // Sign-extend an operand to the sum width
  function automatic logic signed [SumW-1:0] sext_fn(input logic [DataWidth-1:0] v);
    sext_fn = {{(SumW-DataWidth){v[DataWidth-1]}}, v};
  endfunction

  // Clamp to the signed DataWidth range
  function automatic sat_t sat_fn(input logic signed [SumW-1:0] v);
    sat_t s;
    logic fits;
    fits = (v[SumW-1:DataWidth-1] == '0) || (v[SumW-1:DataWidth-1] == '1);
    if (fits) begin
      s.val = v[DataWidth-1:0];
      s.ovf = 1'b0;
    end else begin
      s.val = v[SumW-1] ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
      s.ovf = 1'b1;
    end
    return s;
  endfunction

endpackage

### rtl/core/complex_alu_with_magnitude_top.sv
// Top level of the complex ALU with magnitude: front end, root cell chain, output stage.
// Depends on cawm_pkg, cawm_front, cawm_sqrt_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "complex_alu_with_magnitude_top_defines.svh"

// Complex ALU on signed Q8.8 operands: add, subtract, multiply, conjugate of a,
// and magnitude of a (floored square root of re^2 + im^2). A new command is
// taken every clock cycle; busy never rises. Each command gives one result,
// shown for exactly one cycle with done_o high, after one multiply stage,
// one sum and saturate stage, one cell per root bit (16) of the square root
// chain, and the output register. Results leave in command order and cannot
// be held off, so the receiver must take every done_o cycle.
module complex_alu_with_magnitude_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            cmd_i,
  input  logic signed [cawm_pkg::DataWidth-1:0] a_re_i,
  input  logic signed [cawm_pkg::DataWidth-1:0] a_im_i,
  input  logic signed [cawm_pkg::DataWidth-1:0] b_re_i,
  input  logic signed [cawm_pkg::DataWidth-1:0] b_im_i,
  output logic signed [cawm_pkg::DataWidth-1:0] res_re_o,
  output logic signed [cawm_pkg::DataWidth-1:0] res_im_o,
  output logic                                  overflow_o,
  output logic                                  done_o
);
  import cawm_pkg::*;

  localparam int Latency = DataWidth + 3;

  cell_t                chain [DataWidth+1];
  cell_t                last;
  logic                 done_q;
  logic [DataWidth-1:0] re_d, re_q, im_d, im_q;
  logic                 ovf_d, ovf_q;

  // The pipeline always moves
  assign busy = 1'b0;

  cawm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start & ~busy),
    .cmd_i  (cmd_i),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .cell_o (chain[0])
  );

  // One cell per root bit
  for (genvar k = 0; k < DataWidth; k++) begin : g_cell
    cawm_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  assign last = chain[DataWidth];

  // Select root or carried result; clamp the root
  always_comb begin
    if (last.pay.mag) begin
      im_d = '0;
      if (last.root[DataWidth-1]) begin
        re_d  = {1'b0, {(DataWidth-1){1'b1}}};
        ovf_d = 1'b1;
      end else begin
        re_d  = last.root;
        ovf_d = 1'b0;
      end
    end else begin
      re_d  = last.pay.re;
      im_d  = last.pay.im;
      ovf_d = last.pay.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q  <= re_d;
    im_q  <= im_d;
    ovf_q <= ovf_d;
  end

  assign res_re_o   = re_q;
  assign res_im_o   = im_q;
  assign overflow_o = ovf_q;
  assign done_o     = done_q;

  // Checks
  `CAWM_ASSERT_IMPL(lat_start_a, start && !busy, ##Latency done_o, "result missing after start")
  `CAWM_ASSERT_IMPL(lat_done_a, done_o, $past(start && !busy, Latency), "result without start")
  `CAWM_ASSERT_IMPL(mag_shape_a, done_o && ($past(cmd_i, Latency) == CmdMag), (res_im_o == '0) && !res_re_o[DataWidth-1], "magnitude result malformed")
  `CAWM_ASSERT_IMPL(mag_sat_a, done_o && overflow_o && ($past(cmd_i, Latency) == CmdMag), res_re_o == {1'b0, {(DataWidth-1){1'b1}}}, "magnitude overflow not clamped")

endmodule

### rtl/core/cawm_front.sv
// Front end: operand multipliers, add/sub/conjugate, product sums and radicand.
// Depends on cawm_pkg.
`timescale 1ns / 1ps

module cawm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            vld_i,
  input  logic [2:0]                      cmd_i,
  input  logic [cawm_pkg::DataWidth-1:0]  a_re_i,
  input  logic [cawm_pkg::DataWidth-1:0]  a_im_i,
  input  logic [cawm_pkg::DataWidth-1:0]  b_re_i,
  input  logic [cawm_pkg::DataWidth-1:0]  b_im_i,
  output cawm_pkg::cell_t                 cell_o
);
  import cawm_pkg::*;

  logic                        v1_q;
  cmd_e                        cmd1_q;
  pay_t                        pay1_d, pay1_q;
  logic signed [ProdW-1:0]     p0_d, p1_d, p2_d, p3_d;
  logic signed [ProdW-1:0]     p0_q, p1_q, p2_q, p3_q;
  logic signed [DataWidth-1:0] ar, ai, br, bi, mr, mi;
  sat_t                        s_re, s_im;

  logic                        v2_q;
  logic [RadW-1:0]             rad_d, rad_q;
  pay_t                        pay2_d, pay2_q;
  logic signed [SumW-1:0]      sum_re, sum_im, sum_mag;
  sat_t                        m_re, m_im;

  // Stage 1: multiply and handle the simple commands
  always_comb begin
    ar = a_re_i;
    ai = a_im_i;
    br = b_re_i;
    bi = b_im_i;
    // square a for magnitude, reusing the first two multipliers
    mr = (cmd_e'(cmd_i) == CmdMag) ? ar : br;
    mi = (cmd_e'(cmd_i) == CmdMag) ? ai : bi;
    p0_d = ar * mr;
    p1_d = ai * mi;
    p2_d = ar * bi;
    p3_d = ai * br;
  end

  always_comb begin
    pay1_d = '0;
    s_re   = '0;
    s_im   = '0;
    case (cmd_e'(cmd_i))
      CmdAdd: begin
        s_re = sat_fn(sext_fn(a_re_i) + sext_fn(b_re_i));
        s_im = sat_fn(sext_fn(a_im_i) + sext_fn(b_im_i));
      end
      CmdSub: begin
        s_re = sat_fn(sext_fn(a_re_i) - sext_fn(b_re_i));
        s_im = sat_fn(sext_fn(a_im_i) - sext_fn(b_im_i));
      end
      CmdConj: begin
        s_re = sat_fn(sext_fn(a_re_i));
        s_im = sat_fn(-sext_fn(a_im_i));
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    pay1_d.re  = s_re.val;
    pay1_d.im  = s_im.val;
    pay1_d.ovf = s_re.ovf | s_im.ovf;
    pay1_d.mag = (cmd_e'(cmd_i) == CmdMag);
  end

  // Hold stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
    end
  end

  // Capture stage 1 data
  always_ff @(posedge clk_i) begin
    cmd1_q <= cmd_e'(cmd_i);
    pay1_q <= pay1_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    p3_q   <= p3_d;
  end

  // Stage 2: sum products, floor-shift and saturate; form radicand
  always_comb begin
    sum_re  = SumW'(p0_q) - SumW'(p1_q);
    sum_im  = SumW'(p2_q) + SumW'(p3_q);
    sum_mag = SumW'(p0_q) + SumW'(p1_q);
    m_re    = sat_fn(sum_re >>> FracBits);
    m_im    = sat_fn(sum_im >>> FracBits);
    rad_d   = sum_mag[RadW-1:0];
    pay2_d  = pay1_q;
    if (cmd1_q == CmdMul) begin
      pay2_d.re  = m_re.val;
      pay2_d.im  = m_im.val;
      pay2_d.ovf = m_re.ovf | m_im.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    pay2_q <= pay2_d;
  end

  // Seed the root chain
  always_comb begin
    cell_o      = '0;
    cell_o.vld  = v2_q;
    cell_o.rad  = rad_q;
    cell_o.rem  = '0;
    cell_o.root = '0;
    cell_o.pay  = pay2_q;
  end

endmodule

### rtl/core/cawm_sqrt_cell.sv
// One digit of the restoring square root; passes the result payload along.
// Depends on cawm_pkg.
`timescale 1ns / 1ps

module cawm_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cawm_pkg::cell_t cell_i,
  output cawm_pkg::cell_t cell_o
);
  import cawm_pkg::*;

  logic [RemW-1:0]      rem_sh;
  logic [RemW-1:0]      trial;
  logic                 take;
  cell_t                cell_d, cell_q;
  logic                 vld_q;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {cell_i.rem[RemW-3:0], cell_i.rad[RadW-1:RadW-2]};
    trial  = {1'b0, cell_i.root, 2'b01};
    take   = (rem_sh >= trial);
    cell_d = cell_i;
    cell_d.rad = {cell_i.rad[RadW-3:0], 2'b00};
    if (take) begin
      cell_d.rem  = rem_sh - trial;
      cell_d.root = {cell_i.root[DataWidth-2:0], 1'b1};
    end else begin
      cell_d.rem  = rem_sh;
      cell_d.root = {cell_i.root[DataWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  // Advance the data to the next cell
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o     = cell_q;
    cell_o.vld = vld_q;
  end

endmodule
